### sv/gmst_pkg.sv
// shared types and constants for the grid spanning tree block
package gmst_pkg;

  localparam int unsigned MAX_NODES_DEF = 32;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned COORD_W = 20;
  localparam int unsigned COST_IN_W = 30;
  localparam int unsigned FACT_W = 31;
  localparam int unsigned DIST_W = 21;
  localparam int unsigned WEIGHT_W = 52;
  localparam int unsigned TOTAL_W = 58;
  localparam int unsigned IN_TDATA_W = 112;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef enum logic [1:0] {
    KIND_TOTAL = 2'd0,
    KIND_STATION = 2'd1,
    KIND_LINK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_MERGE,
    ST_RELABEL,
    ST_OUT_TOTAL,
    ST_LIST_RD,
    ST_LIST_CHK
  } state_e;

  typedef struct packed {
    logic load;
    logic init_start;
    logic scan_start;
    logic merge;
    logic emit_total;
    logic list_rd;
    logic list_skip;
    logic list_emit;
    logic phase_next;
  } cmd_t;

  typedef struct packed {
    logic sweep_busy;
    logic scan_busy;
    logic all_chosen;
    logic out_free;
    logic list_end;
    logic entry_match;
    logic phase_link;
  } status_t;

endpackage

### sv/gmst_ctrl.sv
// solve sequencer state machine
module gmst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  output logic             in_ready_o,
  input  gmst_pkg::status_t sts_i,
  output gmst_pkg::cmd_t   cmd_o
);

  gmst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gmst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gmst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == gmst_pkg::OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.init_start = 1'b1;
            state_d = gmst_pkg::ST_INIT;
          end
        end
      end
      gmst_pkg::ST_INIT: begin
        if (!sts_i.sweep_busy) begin
          cmd_o.scan_start = 1'b1;
          state_d = gmst_pkg::ST_SCAN;
        end
      end
      gmst_pkg::ST_SCAN: begin
        if (!sts_i.scan_busy) begin
          state_d = gmst_pkg::ST_MERGE;
        end
      end
      gmst_pkg::ST_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d = gmst_pkg::ST_RELABEL;
      end
      gmst_pkg::ST_RELABEL: begin
        if (!sts_i.sweep_busy) begin
          if (sts_i.all_chosen) begin
            state_d = gmst_pkg::ST_OUT_TOTAL;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = gmst_pkg::ST_SCAN;
          end
        end
      end
      gmst_pkg::ST_OUT_TOTAL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_total = 1'b1;
          state_d = gmst_pkg::ST_LIST_RD;
        end
      end
      gmst_pkg::ST_LIST_RD: begin
        if (sts_i.list_end) begin
          if (sts_i.phase_link) begin
            state_d = gmst_pkg::ST_IDLE;
          end else begin
            cmd_o.phase_next = 1'b1;
          end
        end else begin
          cmd_o.list_rd = 1'b1;
          state_d = gmst_pkg::ST_LIST_CHK;
        end
      end
      gmst_pkg::ST_LIST_CHK: begin
        if (sts_i.entry_match) begin
          if (sts_i.out_free) begin
            cmd_o.list_emit = 1'b1;
            state_d = gmst_pkg::ST_LIST_RD;
          end
        end else begin
          cmd_o.list_skip = 1'b1;
          state_d = gmst_pkg::ST_LIST_RD;
        end
      end
      default: begin
        state_d = gmst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/gmst_dp.sv
// node stores, edge scan pipeline, component labels, chosen list and output register
module gmst_dp #(
  parameter int unsigned MAX_NODES = gmst_pkg::MAX_NODES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gmst_pkg::cmd_t                      cmd_i,
  output gmst_pkg::status_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [gmst_pkg::NODE_W-1:0]         cfg_wdata_i,
  input  logic [gmst_pkg::NODE_W-1:0]         ld_index_i,
  input  logic [gmst_pkg::COORD_W-1:0]        ld_x_i,
  input  logic [gmst_pkg::COORD_W-1:0]        ld_y_i,
  input  logic [gmst_pkg::COST_IN_W-1:0]      ld_cost_i,
  input  logic [gmst_pkg::COST_IN_W-1:0]      ld_factor_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          out_kind_o,
  output logic [gmst_pkg::NODE_W-1:0]         out_a_o,
  output logic [gmst_pkg::NODE_W-1:0]         out_b_o,
  output logic [gmst_pkg::TOTAL_W-1:0]        out_cost_o,
  output logic                                out_last_o
);

  localparam int unsigned LW = $clog2(MAX_NODES + 1);
  localparam int unsigned DEPTH = MAX_NODES + 1;
  localparam int unsigned NW = 2 * gmst_pkg::COORD_W + 2 * gmst_pkg::COST_IN_W;
  localparam int unsigned EW = 2 * LW + gmst_pkg::WEIGHT_W;

  typedef logic [LW-1:0] idx_t;
  typedef logic [gmst_pkg::WEIGHT_W-1:0] weight_t;

  // configuration
  logic [gmst_pkg::NODE_W-1:0] node_count_q;
  idx_t n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= gmst_pkg::NODE_W'(1);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (node_count_q == '0) begin
      n = idx_t'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n = idx_t'(MAX_NODES);
    end else begin
      n = idx_t'(node_count_q);
    end
  end

  // node store
  logic [NW-1:0] node_mem [DEPTH];
  logic [NW-1:0] na_q, nb_q;
  idx_t iss_lo_q, iss_hi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ld_index_i != '0 && 32'(ld_index_i) <= MAX_NODES) begin
      node_mem[idx_t'(ld_index_i)] <= {ld_factor_i, ld_cost_i, ld_y_i, ld_x_i};
    end
    na_q <= node_mem[iss_lo_q];
    nb_q <= node_mem[iss_hi_q];
  end

  // label sweep control
  logic sw_act_q, sw_init_q, sw_wr_q;
  idx_t sw_v_q, sw_wv_q;
  idx_t best_lo_q, best_hi_q, best_la_q, best_lb_q;
  weight_t best_w_q;
  logic best_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_act_q <= 1'b0;
      sw_init_q <= 1'b0;
      sw_wr_q <= 1'b0;
      sw_v_q <= '0;
      sw_wv_q <= '0;
    end else begin
      sw_wr_q <= sw_act_q && !sw_init_q;
      sw_wv_q <= sw_v_q;
      if (cmd_i.init_start || cmd_i.merge) begin
        sw_act_q <= 1'b1;
        sw_init_q <= cmd_i.init_start;
        sw_v_q <= '0;
      end else if (sw_act_q) begin
        if (sw_v_q == n) begin
          sw_act_q <= 1'b0;
        end
        sw_v_q <= idx_t'(sw_v_q + 1'b1);
      end
    end
  end

  // component labels
  idx_t label_mem [DEPTH];
  idx_t la_q, lb_q, addr_a;

  assign addr_a = sw_act_q ? sw_v_q : iss_lo_q;

  always_ff @(posedge clk_i) begin
    if (sw_act_q && sw_init_q) begin
      label_mem[sw_v_q] <= sw_v_q;
    end else if (sw_wr_q && la_q == best_la_q) begin
      label_mem[sw_wv_q] <= best_lb_q;
    end
    la_q <= label_mem[addr_a];
    lb_q <= label_mem[iss_hi_q];
  end

  // edge enumeration
  logic iss_act_q, iss_virt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_act_q <= 1'b0;
      iss_virt_q <= 1'b0;
      iss_lo_q <= '0;
      iss_hi_q <= '0;
    end else if (cmd_i.scan_start) begin
      iss_act_q <= 1'b1;
      if (n == idx_t'(1)) begin
        iss_virt_q <= 1'b1;
        iss_lo_q <= '0;
        iss_hi_q <= idx_t'(1);
      end else begin
        iss_virt_q <= 1'b0;
        iss_lo_q <= idx_t'(1);
        iss_hi_q <= idx_t'(2);
      end
    end else if (iss_act_q) begin
      if (iss_virt_q) begin
        if (iss_hi_q == n) begin
          iss_act_q <= 1'b0;
        end else begin
          iss_hi_q <= idx_t'(iss_hi_q + 1'b1);
        end
      end else if (iss_hi_q == n) begin
        if (iss_lo_q == idx_t'(n - 1'b1)) begin
          iss_virt_q <= 1'b1;
          iss_lo_q <= '0;
          iss_hi_q <= idx_t'(1);
        end else begin
          iss_lo_q <= idx_t'(iss_lo_q + 1'b1);
          iss_hi_q <= idx_t'(iss_lo_q + 2'd2);
        end
      end else begin
        iss_hi_q <= idx_t'(iss_hi_q + 1'b1);
      end
    end
  end

  // scan pipeline
  logic s1v_q, s1virt_q, s2v_q, s2virt_q, s2cross_q, s3v_q, s3cross_q;
  idx_t s1lo_q, s1hi_q, s2lo_q, s2hi_q, s2la_q, s2lb_q, s3lo_q, s3hi_q, s3la_q, s3lb_q;
  logic [gmst_pkg::FACT_W-1:0] s2f_q;
  logic [gmst_pkg::DIST_W-1:0] s2d_q;
  logic [gmst_pkg::COST_IN_W-1:0] s2c_q;
  weight_t s3w_q;
  logic [gmst_pkg::COORD_W-1:0] xa, xb, ya, yb, dx, dy;
  logic [gmst_pkg::COST_IN_W-1:0] ka, kb;

  assign xa = na_q[gmst_pkg::COORD_W-1:0];
  assign xb = nb_q[gmst_pkg::COORD_W-1:0];
  assign ya = na_q[2*gmst_pkg::COORD_W-1:gmst_pkg::COORD_W];
  assign yb = nb_q[2*gmst_pkg::COORD_W-1:gmst_pkg::COORD_W];
  assign ka = na_q[NW-1:NW-gmst_pkg::COST_IN_W];
  assign kb = nb_q[NW-1:NW-gmst_pkg::COST_IN_W];
  assign dx = (xa > xb) ? xa - xb : xb - xa;
  assign dy = (ya > yb) ? ya - yb : yb - ya;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q <= 1'b0;
      s2v_q <= 1'b0;
      s3v_q <= 1'b0;
    end else begin
      s1v_q <= iss_act_q && !cmd_i.scan_start;
      s2v_q <= s1v_q;
      s3v_q <= s2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1lo_q <= iss_lo_q;
    s1hi_q <= iss_hi_q;
    s1virt_q <= iss_virt_q;
    s2lo_q <= s1lo_q;
    s2hi_q <= s1hi_q;
    s2virt_q <= s1virt_q;
    s2la_q <= la_q;
    s2lb_q <= lb_q;
    s2cross_q <= la_q != lb_q;
    s2f_q <= gmst_pkg::FACT_W'(ka) + gmst_pkg::FACT_W'(kb);
    s2d_q <= gmst_pkg::DIST_W'(dx) + gmst_pkg::DIST_W'(dy);
    s2c_q <= nb_q[NW-gmst_pkg::COST_IN_W-1:2*gmst_pkg::COORD_W];
    s3lo_q <= s2lo_q;
    s3hi_q <= s2hi_q;
    s3la_q <= s2la_q;
    s3lb_q <= s2lb_q;
    s3cross_q <= s2cross_q;
    s3w_q <= s2virt_q ? weight_t'(s2c_q) : weight_t'(s2f_q) * weight_t'(s2d_q);
  end

  // running minimum over crossing edges, earliest wins on ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      best_found_q <= 1'b0;
    end else if (s3v_q && s3cross_q && (!best_found_q || s3w_q < best_w_q)) begin
      best_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3v_q && s3cross_q && (!best_found_q || s3w_q < best_w_q)) begin
      best_w_q <= s3w_q;
      best_lo_q <= s3lo_q;
      best_hi_q <= s3hi_q;
      best_la_q <= s3la_q;
      best_lb_q <= s3lb_q;
    end
  end

  // chosen edge list
  logic [EW-1:0] list_mem [DEPTH];
  logic [EW-1:0] ent_q;
  idx_t cnt_q, k_q, r_q;
  logic [gmst_pkg::TOTAL_W-1:0] total_q;
  logic phase_q;
  idx_t ent_lo, ent_hi;
  weight_t ent_w;

  assign ent_w = ent_q[gmst_pkg::WEIGHT_W-1:0];
  assign ent_hi = ent_q[gmst_pkg::WEIGHT_W+LW-1:gmst_pkg::WEIGHT_W];
  assign ent_lo = ent_q[EW-1:gmst_pkg::WEIGHT_W+LW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.merge) begin
      list_mem[cnt_q] <= {best_lo_q, best_hi_q, best_w_q};
    end
    if (cmd_i.list_rd) begin
      ent_q <= list_mem[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q <= '0;
      r_q <= '0;
      phase_q <= 1'b0;
      total_q <= '0;
    end else begin
      if (cmd_i.init_start) begin
        cnt_q <= '0;
        total_q <= '0;
      end else if (cmd_i.merge) begin
        cnt_q <= idx_t'(cnt_q + 1'b1);
        total_q <= total_q + gmst_pkg::TOTAL_W'(best_w_q);
      end
      if (cmd_i.emit_total) begin
        k_q <= '0;
        r_q <= idx_t'(1);
        phase_q <= 1'b0;
      end else if (cmd_i.phase_next) begin
        k_q <= '0;
        phase_q <= 1'b1;
      end else if (cmd_i.list_skip || cmd_i.list_emit) begin
        k_q <= idx_t'(k_q + 1'b1);
      end
      if (cmd_i.list_emit) begin
        r_q <= idx_t'(r_q + 1'b1);
      end
    end
  end

  // output register
  logic ovalid_q;
  logic out_free;

  assign out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_total || cmd_i.list_emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_total) begin
      out_kind_o <= gmst_pkg::KIND_TOTAL;
      out_a_o <= '0;
      out_b_o <= '0;
      out_cost_o <= total_q;
      out_last_o <= cnt_q == '0;
    end else if (cmd_i.list_emit) begin
      out_kind_o <= phase_q ? gmst_pkg::KIND_LINK : gmst_pkg::KIND_STATION;
      out_a_o <= phase_q ? gmst_pkg::NODE_W'(ent_lo) : gmst_pkg::NODE_W'(ent_hi);
      out_b_o <= phase_q ? gmst_pkg::NODE_W'(ent_hi) : '0;
      out_cost_o <= gmst_pkg::TOTAL_W'(ent_w);
      out_last_o <= r_q == cnt_q;
    end
  end

  assign out_valid_o = ovalid_q;

  assign sts_o.sweep_busy = sw_act_q || sw_wr_q;
  assign sts_o.scan_busy = iss_act_q || s1v_q || s2v_q || s3v_q;
  assign sts_o.all_chosen = cnt_q == n;
  assign sts_o.out_free = out_free;
  assign sts_o.list_end = k_q == cnt_q;
  assign sts_o.entry_match = (ent_lo == '0) != phase_q;
  assign sts_o.phase_link = phase_q;

endmodule

### sv/grid_mst_with_virtual_source.sv
// top level of the grid spanning tree block with a virtual source node
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser opcode, tdata node fields
//  m_axis    out  m_axis_tvalid/tready       tuser kind, tdata nodes and cost, tlast
//  cfg       in   cfg_we_i                   node_count
//
// a load item is written when accepted; a solve over n nodes, with an edge per
// node pair and per node to the virtual source, runs one full edge scan per chosen
// edge followed by a label sweep, then two passes over the chosen list
// reset clears all control state; node stores need a load before use
// a stalled output holds the result register and the list walk waits on it
module grid_mst_with_virtual_source #(
  parameter int unsigned MAX_NODES = gmst_pkg::MAX_NODES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gmst_pkg::NODE_W-1:0]         cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // node_index, coord_x, coord_y, station_cost, link_factor, zero pad
  input  logic [gmst_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // opcode
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // node_a, node_b, cost, zero pad
  output logic [gmst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // kind
  output logic [1:0]                          m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);

  gmst_pkg::cmd_t cmd;
  gmst_pkg::status_t sts;
  logic [gmst_pkg::NODE_W-1:0] out_a, out_b;
  logic [gmst_pkg::TOTAL_W-1:0] out_cost;

  gmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gmst_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ld_index_i  (s_axis_tdata_i[5:0]),
    .ld_x_i      (s_axis_tdata_i[25:6]),
    .ld_y_i      (s_axis_tdata_i[45:26]),
    .ld_cost_i   (s_axis_tdata_i[75:46]),
    .ld_factor_i (s_axis_tdata_i[105:76]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_a_o     (out_a),
    .out_b_o     (out_b),
    .out_cost_o  (out_cost),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_cost, out_b, out_a};

endmodule

### sv/gmst_checker.sv
// port level checks for the grid spanning tree block
module gmst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  a_total_nodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == gmst_pkg::KIND_TOTAL |->
    m_axis_tdata_o[11:0] == 12'd0)
    else $error("total item carries node numbers");

  a_station_nodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == gmst_pkg::KIND_STATION |->
    m_axis_tdata_o[5:0] != 6'd0 && m_axis_tdata_o[11:6] == 6'd0)
    else $error("bad station node numbers");

  a_link_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == gmst_pkg::KIND_LINK |->
    m_axis_tdata_o[5:0] != 6'd0 && m_axis_tdata_o[5:0] < m_axis_tdata_o[11:6])
    else $error("link endpoints out of order");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 2'd3)
    else $error("unknown result kind");

endmodule

bind grid_mst_with_virtual_source gmst_checker u_gmst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

### bench/grid_mst_with_virtual_source_tb.sv
// testbench for the grid spanning tree block: directed and random loads and solves checked against a predictor
`timescale 1ns / 100ps

module grid_mst_with_virtual_source_tb;

  localparam int unsigned NMAX = 32;
  localparam int unsigned EDGE_MAX = NMAX * (NMAX + 1) / 2;
  localparam int unsigned IDLE_LIMIT = 200000;

  typedef struct {
    gmst_pkg::kind_e kind;
    logic [5:0] node_a;
    logic [5:0] node_b;
    logic [57:0] cost;
    logic last;
  } tree_result_t;

  class mst_scoreboard;
    logic [19:0] x_mem [1:NMAX];
    logic [19:0] y_mem [1:NMAX];
    logic [29:0] station_mem [1:NMAX];
    logic [29:0] factor_mem [1:NMAX];
    logic [5:0] node_count;
    tree_result_t pending_results [$];
    int mismatches;

    function new();
      node_count = 6'd1;
      mismatches = 0;
    endfunction

    function void set_node_count(logic [5:0] value);
      node_count = value;
    endfunction

    function void queue_expected(tree_result_t res);
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void solve_tree();
      logic [51:0] weight [EDGE_MAX];
      logic [5:0] lo [EDGE_MAX];
      logic [5:0] hi [EDGE_MAX];
      logic [5:0] parent [0:NMAX];
      int chosen_idx [NMAX];
      logic [51:0] w_tmp;
      logic [5:0] lo_tmp, hi_tmp;
      logic [30:0] fsum;
      logic [20:0] manh_dist;
      logic [57:0] total;
      tree_result_t res;
      int n, m, p, chosen, ra, rb, r;
      n = node_count;
      if (n < 1) n = 1;
      if (n > NMAX) n = NMAX;
      m = 0;
      for (int i = 1; i < n; i++) begin
        for (int j = i + 1; j <= n; j++) begin
          fsum = {1'b0, factor_mem[i]} + {1'b0, factor_mem[j]};
          manh_dist = ((x_mem[i] > x_mem[j]) ? x_mem[i] - x_mem[j] : x_mem[j] - x_mem[i]) +
                      ((y_mem[i] > y_mem[j]) ? 21'(y_mem[i] - y_mem[j]) :
                                               21'(y_mem[j] - y_mem[i]));
          weight[m] = 52'(fsum) * 52'(manh_dist);
          lo[m] = 6'(i);
          hi[m] = 6'(j);
          m++;
        end
      end
      for (int i = 1; i <= n; i++) begin
        weight[m] = 52'(station_mem[i]);
        lo[m] = 6'd0;
        hi[m] = 6'(i);
        m++;
      end
      for (int i = 1; i < m; i++) begin
        w_tmp = weight[i];
        lo_tmp = lo[i];
        hi_tmp = hi[i];
        p = i;
        while (p > 0 && weight[p - 1] > w_tmp) begin
          weight[p] = weight[p - 1];
          lo[p] = lo[p - 1];
          hi[p] = hi[p - 1];
          p--;
        end
        weight[p] = w_tmp;
        lo[p] = lo_tmp;
        hi[p] = hi_tmp;
      end
      for (int i = 0; i <= NMAX; i++) parent[i] = 6'(i);
      total = '0;
      chosen = 0;
      for (int i = 0; i < m && chosen < NMAX; i++) begin
        ra = lo[i];
        while (parent[ra] != ra) ra = parent[ra];
        rb = hi[i];
        while (parent[rb] != rb) rb = parent[rb];
        if (ra != rb) begin
          parent[ra] = 6'(rb);
          total = total + 58'(weight[i]);
          chosen_idx[chosen] = i;
          chosen++;
        end
      end
      res = '{gmst_pkg::KIND_TOTAL, 6'd0, 6'd0, total, chosen == 0};
      queue_expected(res);
      r = 1;
      for (int k = 0; k < chosen; k++) begin
        if (lo[chosen_idx[k]] == 0) begin
          res = '{gmst_pkg::KIND_STATION, hi[chosen_idx[k]], 6'd0,
                  58'(weight[chosen_idx[k]]), r == chosen};
          queue_expected(res);
          r++;
        end
      end
      for (int k = 0; k < chosen; k++) begin
        if (lo[chosen_idx[k]] != 0) begin
          res = '{gmst_pkg::KIND_LINK, lo[chosen_idx[k]], hi[chosen_idx[k]],
                  58'(weight[chosen_idx[k]]), r == chosen};
          queue_expected(res);
          r++;
        end
      end
    endfunction

    function void note_input(logic op, logic [5:0] idx, logic [19:0] x, logic [19:0] y,
                             logic [29:0] c, logic [29:0] k);
      if (op == gmst_pkg::OP_LOAD) begin
        if (idx >= 1 && idx <= NMAX) begin
          x_mem[idx] = x;
          y_mem[idx] = y;
          station_mem[idx] = c;
          factor_mem[idx] = k;
        end
      end else begin
        solve_tree();
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [5:0] a, logic [5:0] b,
                               logic [57:0] cost, logic last);
      tree_result_t exp_res;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d a=%0d b=%0d cost=%0d last=%0b",
                   kind, a, b, cost, last);
        return;
      end
      exp_res = pending_results.pop_front();
      if (kind !== exp_res.kind || a !== exp_res.node_a || b !== exp_res.node_b ||
          cost !== exp_res.cost || last !== exp_res.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp kind=%0d a=%0d b=%0d cost=%0d last=%0b got %0d %0d %0d %0d %0b",
                   exp_res.kind, exp_res.node_a, exp_res.node_b, exp_res.cost, exp_res.last,
                   kind, a, b, cost, last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [gmst_pkg::NODE_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [gmst_pkg::IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [gmst_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  mst_scoreboard tree_sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int cycle_cnt = 0;
  int stall_pct = 0;
  bit node_loaded [1:NMAX];

  always #6 clk_i = ~clk_i;

  grid_mst_with_virtual_source uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o),
    .m_axis_tlast_o(m_axis_tlast_o)
  );

  // result side: check, stall pattern and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (m_axis_tvalid_o && m_axis_tready_i)
        tree_sb.check_result(m_axis_tuser_o, m_axis_tdata_o[5:0], m_axis_tdata_o[11:6],
                             m_axis_tdata_o[69:12], m_axis_tlast_o);
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (cycle_cnt % 300 == 0)
        stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [29:0] pick_value(int width);
    logic [29:0] full;
    full = (30'h3FFFFFFF >> (30 - width));
    case ($urandom_range(0, 7))
      0: return '0;
      1: return full;
      2: return 30'($urandom_range(0, 15));
      default: return 30'($urandom) & full;
    endcase
  endfunction

  task automatic send_item(logic op, logic [5:0] idx, logic [19:0] x, logic [19:0] y,
                           logic [29:0] c, logic [29:0] k);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {6'd0, k, c, y, x, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tree_sb.note_input(op, idx, x, y, c, k);
    if (op == gmst_pkg::OP_LOAD && idx >= 1 && idx <= NMAX) node_loaded[idx] = 1'b1;
  endtask

  task automatic load_random(logic [5:0] idx);
    send_item(gmst_pkg::OP_LOAD, idx, 20'(pick_value(20)), 20'(pick_value(20)),
              pick_value(30), pick_value(30));
  endtask

  task automatic solve_now(logic [5:0] count);
    int n;
    n = (count < 1) ? 1 : (count > NMAX) ? NMAX : count;
    for (int i = 1; i <= n; i++)
      if (!node_loaded[i]) load_random(6'(i));
    send_item(gmst_pkg::OP_SOLVE, 6'($urandom), 20'($urandom), 20'($urandom),
              30'($urandom), 30'($urandom));
  endtask

  task automatic write_node_count(logic [5:0] value);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tree_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tree_sb.set_node_count(value);
  endtask

  initial begin
    logic [5:0] counts [12];
    int n_eff;
    counts = '{6'd4, 6'd1, 6'd32, 6'd0, 6'd7, 6'd63, 6'd12,
               6'd2, 6'd33, 6'd20, 6'd9, 6'd5};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, bad indexes, ties
    send_item(gmst_pkg::OP_LOAD, 6'd1, 20'hFFFFF, 20'hFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF);
    send_item(gmst_pkg::OP_LOAD, 6'd2, 20'd0, 20'd0, 30'd0, 30'h3FFFFFFF);
    send_item(gmst_pkg::OP_LOAD, 6'd0, 20'd5, 20'd5, 30'd5, 30'd5);
    send_item(gmst_pkg::OP_LOAD, 6'd63, 20'd7, 20'd7, 30'd7, 30'd7);
    send_item(gmst_pkg::OP_LOAD, 6'd33, 20'd9, 20'd9, 30'd9, 30'd9);
    solve_now(6'd1);
    solve_now(6'd1);
    write_node_count(6'd2);
    solve_now(6'd2);
    write_node_count(6'd3);
    send_item(gmst_pkg::OP_LOAD, 6'd1, 20'd10, 20'd0, 30'd100, 30'd0);
    send_item(gmst_pkg::OP_LOAD, 6'd2, 20'd0, 20'd10, 30'd100, 30'd0);
    send_item(gmst_pkg::OP_LOAD, 6'd3, 20'd3, 20'd3, 30'd100, 30'd0);
    solve_now(6'd3);
    send_item(gmst_pkg::OP_LOAD, 6'd1, 20'd0, 20'd0, 30'd0, 30'd1);
    send_item(gmst_pkg::OP_LOAD, 6'd2, 20'd0, 20'd0, 30'd0, 30'd1);
    send_item(gmst_pkg::OP_LOAD, 6'd3, 20'd1, 20'd1, 30'd4, 30'd1);
    solve_now(6'd3);

    // random phases over several node counts
    foreach (counts[p]) begin
      write_node_count(counts[p]);
      n_eff = (counts[p] < 1) ? 1 : (counts[p] > NMAX) ? NMAX : counts[p];
      for (int it = 0; it < 32; it++) begin
        if ($urandom_range(0, 7) == 0 && (n_eff <= 20 || it % 16 == 15))
          solve_now(counts[p]);
        else if ($urandom_range(0, 19) == 0)
          load_random(($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63)));
        else
          load_random(6'($urandom_range(1, n_eff)));
      end
      solve_now(counts[p]);
    end

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (tree_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tree_sb.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
